[sv/skvt_pkg.sv]
// Shared types and constants for the sorted key/value table.
package skvt_pkg;

  // Field widths fixed by the port contract.
  localparam int OPCODE_W = 2;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;
  localparam int CAP_W    = 5;

  // Defaults for the top-level parameters.
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int KEY_BITS_DEF    = 32;
  localparam int VALUE_BITS_DEF  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_MISSING = 3'd2,
    ST_FULL    = 3'd3,
    ST_RANGE   = 3'd4
  } status_t;

  // Result of the shared key comparator: request key against stored key.
  typedef struct packed {
    logic le;
    logic eq;
  } cmp_t;

endpackage

[sv/skvt_mem.sv]
// Key and value storage: one write port, one read port with registered data.
module skvt_mem #(
  parameter int DEPTH  = 16,
  parameter int AW     = 4,
  parameter int KBITS  = 32,
  parameter int VBITS  = 32
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [KBITS-1:0] wr_key,
  input  logic [VBITS-1:0] wr_val,
  input  logic [AW-1:0]    rd_addr,
  output logic [KBITS-1:0] rd_key,
  output logic [VBITS-1:0] rd_val
);

  logic [KBITS-1:0] key_mem [DEPTH];
  logic [VBITS-1:0] val_mem [DEPTH];
  logic [KBITS-1:0] rd_key_r;
  logic [VBITS-1:0] rd_val_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    rd_key_r <= key_mem[rd_addr];
    rd_val_r <= val_mem[rd_addr];
  end

  assign rd_key = rd_key_r;
  assign rd_val = rd_val_r;

endmodule

[sv/skvt_cmp.sv]
// Shared key comparator used on every step of the scan.
module skvt_cmp #(
  parameter int KBITS = 32
) (
  input  logic [KBITS-1:0] req_key,
  input  logic [KBITS-1:0] mem_key,
  output skvt_pkg::cmp_t   res
);

  import skvt_pkg::*;

  always_comb begin
    res.le = (req_key <= mem_key);
    res.eq = (req_key == mem_key);
  end

endmodule

[sv/sorted_key_value_table_core.sv]
// Sorted key/value table: one B+ tree leaf kept in ascending key order.
//
//   Channel | Direction | Handshake        | Payload
//   --------+-----------+------------------+------------------------------------------
//   in_     | in        | in_valid/stall   | opcode, key, value, index
//   out_    | out       | out_valid/stall  | status, entry_index, key_out, value_out,
//           |           |                  | entry_count
//   cfg_    | in        | cfg_valid/ready  | capacity_in_use (write data only)
//
// Sequencing: one request at a time. The scan reads one stored entry per cycle
//   through the single memory read port and stops at the first key not below
//   the request key. Insert then shifts one entry per cycle from the end down
//   to its slot and writes the pair; delete shifts the tail down one entry per
//   cycle. Scan and shift together touch at most MAX_ENTRIES entries.
// Reset: clears the fill count, capacity (to 16) and control; the store is
//   not cleared, since only entries below the fill count are ever read.
// Stalls: a result waits in the output register; in_stall drops as soon as
//   that word has been loaded, so the next request may start underneath it.
module sorted_key_value_table_core #(
  parameter int MAX_ENTRIES = skvt_pkg::MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = skvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS  = skvt_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request word
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [skvt_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [skvt_pkg::KEY_W-1:0]    in_key,
  input  logic [skvt_pkg::VALUE_W-1:0]  in_value,
  input  logic [skvt_pkg::INDEX_W-1:0]  in_index,
  // result word
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [skvt_pkg::STATUS_W-1:0] out_status,
  output logic [skvt_pkg::INDEX_W-1:0]  out_entry_index,
  output logic [skvt_pkg::KEY_W-1:0]    out_key_out,
  output logic [skvt_pkg::VALUE_W-1:0]  out_value_out,
  output logic [skvt_pkg::COUNT_W-1:0]  out_entry_count,
  // capacity register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [skvt_pkg::CAP_W-1:0]    cfg_data
);

  import skvt_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int IW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE,    // wait for a request word
    S_SCAN,    // compare one stored key per cycle
    S_DECIDE,  // pick the outcome from the scan
    S_SHUP,    // move entries up to open a slot
    S_SHDN,    // move entries down to close a slot
    S_PLACE,   // write the new pair into its slot
    S_RDIDX,   // take the pair read at an index
    S_FIN      // hand the result to the output register
  } state_t;

  state_t                state_r;
  op_t                   op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [INDEX_W-1:0]    idx_r;
  logic [IW-1:0]         fill_r;
  logic [IW-1:0]         cnt_r;
  logic [IW-1:0]         at_r;
  logic                  eq_r;
  logic [KEY_BITS-1:0]   hit_key_r;
  logic [VALUE_BITS-1:0] hit_val_r;
  logic [CAP_W-1:0]      cap_r;

  status_t               res_status_r;
  logic [AW-1:0]         res_pos_r;
  logic [KEY_BITS-1:0]   res_key_r;
  logic [VALUE_BITS-1:0] res_val_r;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [INDEX_W-1:0]    out_index_r;
  logic [KEY_W-1:0]      out_key_r;
  logic [VALUE_W-1:0]    out_val_r;
  logic [COUNT_W-1:0]    out_count_r;

  // memory and comparator hookup
  logic [IW-1:0]         rd_ptr;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [IW-1:0]         wr_ptr;
  logic [KEY_BITS-1:0]   wr_key;
  logic [VALUE_BITS-1:0] wr_val;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  cmp_t                  cmp;

  logic [31:0]           cap_eff;
  logic                  is_full;
  logic                  in_take;
  logic                  out_free;

  assign in_take   = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  // Clamp the capacity register into 1..MAX_ENTRIES.
  always_comb begin
    cap_eff = 32'(cap_r);
    if (cap_eff == 32'd0) begin
      cap_eff = 32'd1;
    end else if (cap_eff > 32'(MAX_ENTRIES)) begin
      cap_eff = 32'(MAX_ENTRIES);
    end
    is_full = (32'(fill_r) >= cap_eff);
  end

  // Memory address for the read that lands next cycle. Reads are always
  // issued; a read whose data is not needed is simply ignored.
  always_comb begin
    unique case (state_r)
      S_IDLE:   rd_ptr = (in_opcode == OP_READ) ? IW'(in_index) : '0;
      S_SCAN:   rd_ptr = cnt_r + 1'b1;
      S_DECIDE: rd_ptr = (op_r == OP_INSERT) ? (fill_r - 1'b1) : (at_r + 1'b1);
      S_SHUP:   rd_ptr = cnt_r - 2'd2;
      S_SHDN:   rd_ptr = cnt_r + 2'd2;
      default:  rd_ptr = '0;
    endcase
  end

  assign rd_addr = rd_ptr[AW-1:0];

  // Shifts write the entry just read; the final insert step writes the new pair.
  always_comb begin
    wr_en  = (state_r == S_SHUP) || (state_r == S_SHDN) || (state_r == S_PLACE);
    wr_ptr = (state_r == S_PLACE) ? at_r : cnt_r;
    wr_key = (state_r == S_PLACE) ? key_r : rd_key;
    wr_val = (state_r == S_PLACE) ? val_r : rd_val;
  end

  skvt_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW),
    .KBITS (KEY_BITS),
    .VBITS (VALUE_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_ptr[AW-1:0]),
    .wr_key  (wr_key),
    .wr_val  (wr_val),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_val  (rd_val)
  );

  skvt_cmp #(
    .KBITS (KEY_BITS)
  ) u_cmp (
    .req_key (key_r),
    .mem_key (rd_key),
    .res     (cmp)
  );

  // Sequencer: state, table bookkeeping and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      // Drop the result word once the consumer takes it; the finish step
      // reloads the register on its own.
      if (out_valid_r && !out_stall && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            op_r  <= op_t'(in_opcode);
            key_r <= KEY_BITS'(in_key);
            val_r <= VALUE_BITS'(in_value);
            idx_r <= in_index;
            cnt_r <= '0;
            if (op_t'(in_opcode) == OP_READ) begin
              if (32'(in_index) >= 32'(fill_r)) begin
                res_status_r <= ST_RANGE;
                res_pos_r    <= '0;
                res_key_r    <= '0;
                res_val_r    <= '0;
                state_r      <= S_FIN;
              end else begin
                state_r <= S_RDIDX;
              end
            end else if (fill_r == '0) begin
              at_r    <= '0;
              eq_r    <= 1'b0;
              state_r <= S_DECIDE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          // Stop at the first stored key not below the request key.
          if (cmp.le) begin
            at_r      <= cnt_r;
            eq_r      <= cmp.eq;
            hit_key_r <= rd_key;
            hit_val_r <= rd_val;
            state_r   <= S_DECIDE;
          end else if ((cnt_r + 1'b1) == fill_r) begin
            at_r    <= fill_r;
            eq_r    <= 1'b0;
            state_r <= S_DECIDE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end

        S_DECIDE: begin
          res_pos_r <= '0;
          res_key_r <= '0;
          res_val_r <= '0;
          unique case (op_r)
            OP_INSERT: begin
              // Duplicate wins over full: the scan already ran.
              if (eq_r) begin
                res_status_r <= ST_DUP;
                state_r      <= S_FIN;
              end else if (is_full) begin
                res_status_r <= ST_FULL;
                state_r      <= S_FIN;
              end else if (at_r == fill_r) begin
                state_r <= S_PLACE;
              end else begin
                cnt_r   <= fill_r;
                state_r <= S_SHUP;
              end
            end
            OP_DELETE, OP_SEARCH: begin
              if (!eq_r) begin
                res_status_r <= ST_MISSING;
                state_r      <= S_FIN;
              end else begin
                res_status_r <= ST_OK;
                res_pos_r    <= at_r[AW-1:0];
                res_key_r    <= hit_key_r;
                res_val_r    <= hit_val_r;
                if (op_r == OP_DELETE && (at_r + 1'b1) < fill_r) begin
                  cnt_r   <= at_r;
                  state_r <= S_SHDN;
                end else begin
                  if (op_r == OP_DELETE) begin
                    fill_r <= fill_r - 1'b1;
                  end
                  state_r <= S_FIN;
                end
              end
            end
            OP_READ: begin
              state_r <= S_FIN;
            end
          endcase
        end

        S_SHUP: begin
          // Entry cnt-1 is written to cnt this cycle.
          if ((cnt_r - 1'b1) == at_r) begin
            state_r <= S_PLACE;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end

        S_SHDN: begin
          // Entry cnt+1 is written to cnt this cycle.
          if ((cnt_r + 2'd2) == fill_r) begin
            fill_r  <= fill_r - 1'b1;
            state_r <= S_FIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end

        S_PLACE: begin
          fill_r       <= fill_r + 1'b1;
          res_status_r <= ST_OK;
          res_pos_r    <= at_r[AW-1:0];
          res_key_r    <= key_r;
          res_val_r    <= val_r;
          state_r      <= S_FIN;
        end

        S_RDIDX: begin
          res_status_r <= ST_OK;
          res_pos_r    <= AW'(idx_r);
          res_key_r    <= rd_key;
          res_val_r    <= rd_val;
          state_r      <= S_FIN;
        end

        S_FIN: begin
          // Hold until the output register is free, then load it.
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_index_r  <= INDEX_W'(res_pos_r);
            out_key_r    <= KEY_W'(res_key_r);
            out_val_r    <= VALUE_W'(res_val_r);
            out_count_r  <= COUNT_W'(fill_r);
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_index = out_index_r;
  assign out_key_out     = out_key_r;
  assign out_value_out   = out_val_r;
  assign out_entry_count = out_count_r;

  // The fill count never passes the table depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= 32'(MAX_ENTRIES))
    else $error("fill count beyond table depth");

  // The store is written only while shifting or placing a pair.
  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_SHUP || state_r == S_SHDN || state_r == S_PLACE))
    else $error("store written outside a shift or place step");

  // Placing a pair adds exactly one entry.
  a_place_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLACE) |=> (fill_r == $past(fill_r) + 1'b1))
    else $error("insert did not add one entry");

  // A new result word only appears out of the finish step.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result word raised outside the finish step");

  // An accepted request always leaves the idle state.
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

endmodule

[bench/sorted_table_checker.sv]
// Checker for the sorted key/value table: tracks the table, predicts each result word and compares.
`timescale 1ns / 100ps

module sorted_table_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [skvt_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [skvt_pkg::KEY_W-1:0]    in_key,
  input  logic [skvt_pkg::VALUE_W-1:0]  in_value,
  input  logic [skvt_pkg::INDEX_W-1:0]  in_index,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [skvt_pkg::STATUS_W-1:0] out_status,
  input  logic [skvt_pkg::INDEX_W-1:0]  out_entry_index,
  input  logic [skvt_pkg::KEY_W-1:0]    out_key_out,
  input  logic [skvt_pkg::VALUE_W-1:0]  out_value_out,
  input  logic [skvt_pkg::COUNT_W-1:0]  out_entry_count,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [skvt_pkg::CAP_W-1:0]    cfg_data,
  output int                            mismatches,
  output int                            outstanding
);
  import skvt_pkg::*;

  typedef struct packed {
    status_t              status;
    logic [INDEX_W-1:0]   entry;
    logic [KEY_W-1:0]     key;
    logic [VALUE_W-1:0]   value;
    logic [COUNT_W-1:0]   count;
  } table_result_t;

  logic [KEY_W-1:0]   key_copy   [MAX_ENTRIES_DEF];
  logic [VALUE_W-1:0] value_copy [MAX_ENTRIES_DEF];
  int                 pairs;
  logic [CAP_W-1:0]   capacity;
  table_result_t      pending_results [$];

  // Apply one request to the local copy of the table and return its result word.
  function automatic table_result_t apply_request(input op_t op,
                                                  input logic [KEY_W-1:0] k,
                                                  input logic [VALUE_W-1:0] v,
                                                  input logic [INDEX_W-1:0] idx);
    table_result_t r;
    int at;
    int i;
    int limit;
    bit dup;
    bit stop;
    r = '0;
    r.status = ST_OK;
    // capacity zero acts as one, anything above the array size as the array size
    if (capacity == 0) limit = 1;
    else if (capacity > MAX_ENTRIES_DEF) limit = MAX_ENTRIES_DEF;
    else limit = int'(capacity);
    case (op)
      OP_INSERT: begin
        at = pairs;
        dup = 1'b0;
        stop = 1'b0;
        for (i = 0; i < pairs && !stop; i++) begin
          if (k == key_copy[i]) begin
            dup = 1'b1;
            stop = 1'b1;
          end else if (k < key_copy[i]) begin
            at = i;
            stop = 1'b1;
          end
        end
        if (dup) begin
          r.status = ST_DUP;
        end else if (pairs >= limit) begin
          r.status = ST_FULL;
        end else begin
          for (i = pairs; i > at; i--) begin
            key_copy[i] = key_copy[i-1];
            value_copy[i] = value_copy[i-1];
          end
          key_copy[at] = k;
          value_copy[at] = v;
          pairs++;
          r.entry = INDEX_W'(at);
          r.key = k;
          r.value = v;
        end
      end
      OP_DELETE, OP_SEARCH: begin
        at = pairs;
        stop = 1'b0;
        for (i = 0; i < pairs && !stop; i++) begin
          if (k == key_copy[i]) begin
            at = i;
            stop = 1'b1;
          end
        end
        if (at >= pairs) begin
          r.status = ST_MISSING;
        end else begin
          r.entry = INDEX_W'(at);
          r.key = key_copy[at];
          r.value = value_copy[at];
          if (op == OP_DELETE) begin
            for (i = at; i + 1 < pairs; i++) begin
              key_copy[i] = key_copy[i+1];
              value_copy[i] = value_copy[i+1];
            end
            pairs--;
          end
        end
      end
      default: begin
        if (int'(idx) >= pairs) begin
          r.status = ST_RANGE;
        end else begin
          r.entry = idx;
          r.key = key_copy[idx];
          r.value = value_copy[idx];
        end
      end
    endcase
    r.count = COUNT_W'(pairs);
    return r;
  endfunction

  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      pairs = 0;
      capacity = CAP_RESET;
      mismatches = 0;
      pending_results.delete();
      outstanding <= 0;
    end else begin
      // retire the result word first, so a word never matches a request taken at the same edge
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result word with no request outstanding");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            $error("out_status: expected %0d, actual %0d", want.status, out_status);
            mismatches++;
          end
          if (out_entry_index !== want.entry) begin
            $error("out_entry_index: expected %0d, actual %0d", want.entry, out_entry_index);
            mismatches++;
          end
          if (out_key_out !== want.key) begin
            $error("out_key_out: expected %h, actual %h", want.key, out_key_out);
            mismatches++;
          end
          if (out_value_out !== want.value) begin
            $error("out_value_out: expected %h, actual %h", want.value, out_value_out);
            mismatches++;
          end
          if (out_entry_count !== want.count) begin
            $error("out_entry_count: expected %0d, actual %0d", want.count, out_entry_count);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) capacity = cfg_data;
      if (in_valid && !in_stall)
        pending_results.insert(pending_results.size(),
                               apply_request(op_t'(in_opcode), in_key, in_value, in_index));
      outstanding <= pending_results.size();
    end
  end

endmodule

[bench/sorted_key_value_table_core_tb.sv]
// Top of the sorted key/value table bench: clock, reset, request and stall traffic, verdict.
`timescale 1ns / 100ps

module sorted_key_value_table_core_tb;
  import skvt_pkg::*;

  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 128;
  localparam int HOLD_CYCLES  = 200;
  // let a good deal more pass after the last result than the worst request takes
  localparam int TAIL_CYCLES  = 40;

  logic                clk;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic [OPCODE_W-1:0] in_opcode       = '0;
  logic [KEY_W-1:0]    in_key          = '0;
  logic [VALUE_W-1:0]  in_value        = '0;
  logic [INDEX_W-1:0]  in_index        = '0;
  logic                out_valid;
  logic                out_stall       = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [INDEX_W-1:0]  out_entry_index;
  logic [KEY_W-1:0]    out_key_out;
  logic [VALUE_W-1:0]  out_value_out;
  logic [COUNT_W-1:0]  out_entry_count;
  logic                cfg_valid       = 1'b0;
  logic                cfg_ready;
  logic [CAP_W-1:0]    cfg_data        = '0;

  int mismatches;
  int outstanding;

  // hold_request is shared between the request process and the stall process.
  bit hold_request = 1'b0;
  bit no_gaps      = 1'b0;

  logic [KEY_W-1:0] key_pool [32];
  int               pool_span = 32;
  logic [CAP_W-1:0] cap_plan [PHASES] = '{5'd31, 5'd16, 5'd0, 5'd8, 5'd17, 5'd1,
                                          5'd30, 5'd4, 5'd16, 5'd12, 5'd2, 5'd16};

  sorted_key_value_table_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_key          (in_key),
    .in_value        (in_value),
    .in_index        (in_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_key_out     (out_key_out),
    .out_value_out   (out_value_out),
    .out_entry_count (out_entry_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  sorted_table_checker table_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_key          (in_key),
    .in_value        (in_value),
    .in_index        (in_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_key_out     (out_key_out),
    .out_value_out   (out_value_out),
    .out_entry_count (out_entry_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Pick an idle gap for the sender: mostly none or short, now and then long.
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Draw a key: mostly from the pool so that hits and duplicates are common,
  // sometimes a fresh random one as noise.
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, pool_span - 1)];
    return $urandom;
  endfunction

  // Insert-heavy stretches fill the table, delete-heavy ones drain it.
  function automatic op_t pick_op(input bit insert_heavy);
    int r;
    r = $urandom_range(0, 99);
    if (r < (insert_heavy ? 50 : 15)) return OP_INSERT;
    if (r < 65) return OP_DELETE;
    if (r < 85) return OP_SEARCH;
    return OP_READ;
  endfunction

  // Keep the extreme keys in the pool; refill the rest with random keys.
  task automatic refresh_pool();
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < 32; i++) key_pool[i] = $urandom;
    pool_span = $urandom_range(6, 32);
  endtask

  // Offer one request word and hold it until taken; then idle for a random gap.
  task automatic send_request(input op_t op, input logic [KEY_W-1:0] k,
                              input logic [VALUE_W-1:0] v, input logic [INDEX_W-1:0] idx);
    int gap;
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_key    <= k;
    in_value  <= v;
    in_index  <= idx;
    do @(posedge clk); while (in_stall);
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected result word has arrived.
  // The count is registered, so the task waits on the clock before looking at it.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Write the capacity register; only called while the table is idle.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Receiver side: random stall pattern, with runs free of stalls, and one
  // long hold-off when the request process asks for it.
  initial begin
    int run_len;
    int stall_len;
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        run_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
        stall_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
        out_stall <= 1'b0;
        repeat (run_len) @(posedge clk);
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
        end
      end
    end
  end

  // Request side.
  initial begin
    op_t op;
    bit  insert_heavy;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, extreme keys, every operation.
    write_capacity(5'd16);
    send_request(OP_READ,   32'd0,        32'd0,        4'd0);   // read on an empty table
    send_request(OP_SEARCH, 32'd5,        32'd0,        4'd0);
    send_request(OP_DELETE, 32'd5,        32'd0,        4'd0);
    send_request(OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 4'd0);
    send_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000, 4'd0); // lowest key goes in front
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 4'd0); // highest key goes last
    send_request(OP_INSERT, 32'h8000_0000, 32'h0000_0001, 4'd0); // duplicate
    send_request(OP_INSERT, 32'h7FFF_FFFF, 32'h5555_5555, 4'd0); // lands in the middle
    send_request(OP_SEARCH, 32'hFFFF_FFFF, 32'd0,        4'd0);
    send_request(OP_SEARCH, 32'h0000_0000, 32'd0,        4'd0);
    send_request(OP_READ,   32'd0,        32'd0,        4'd3);
    send_request(OP_READ,   32'd0,        32'd0,        4'd4);   // read just past the fill
    send_request(OP_READ,   32'd0,        32'd0,        4'd15);
    send_request(OP_DELETE, 32'h0000_0000, 32'd0,        4'd0);   // remove the front
    send_request(OP_DELETE, 32'hFFFF_FFFF, 32'd0,        4'd0);   // remove the tail

    // Two pairs held, capacity two: a duplicate on a full table still reports duplicate.
    drain_results();
    write_capacity(5'd2);
    send_request(OP_INSERT, 32'h8000_0000, 32'h1234_5678, 4'd0);
    send_request(OP_INSERT, 32'h0000_0001, 32'h1234_5678, 4'd0);

    // Capacity zero acts as one, and sits below the fill: inserts stay full until drained.
    drain_results();
    write_capacity(5'd0);
    send_request(OP_INSERT, 32'd3,        32'hDEAD_BEEF, 4'd0);
    send_request(OP_DELETE, 32'h7FFF_FFFF, 32'd0,        4'd0);
    send_request(OP_INSERT, 32'd3,        32'hDEAD_BEEF, 4'd0);
    send_request(OP_DELETE, 32'h8000_0000, 32'd0,        4'd0);
    send_request(OP_INSERT, 32'd3,        32'hDEAD_BEEF, 4'd0);
    send_request(OP_INSERT, 32'd4,        32'hCAFE_F00D, 4'd0);

    // Capacity above the array size acts as the array size.
    drain_results();
    write_capacity(5'd31);
    send_request(OP_INSERT, 32'd4,        32'hCAFE_F00D, 4'd0);
    send_request(OP_READ,   32'd0,        32'd0,        4'd1);

    // Random phases, each under its own capacity.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      write_capacity(ph == 9 ? 5'($urandom_range(0, 31)) : cap_plan[ph]);
      refresh_pool();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 32 == 0) begin
          insert_heavy = ((n / 32) % 2 == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
          no_gaps = ($urandom_range(0, 3) == 0);
        end
        // Hold the receiver off for a long stretch while requests keep coming back to back.
        if (ph == 2 && n == 40) begin
          hold_request = 1'b1;
          no_gaps = 1'b1;
        end
        // Pause the sender until every result is back.
        if (ph == 6 && n == 64) drain_results();
        op = pick_op(insert_heavy);
        send_request(op, pick_key(), $urandom, 4'($urandom_range(0, 15)));
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop for a hung handshake.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
